@@ rtl/core/qpm_pkg.sv @@
// Shared types and constants for the NVMe queue pair manager.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
package qpm_pkg;

    // Widths fixed by the field definitions.
    localparam int QID_W  = 7;   // wide enough for queue ids 0..127
    localparam int PTR_W  = 12;
    localparam int CAP_W  = 13;
    localparam int MAXF_W = 7;

    // Command codes.
    localparam logic [2:0] CMD_MK_SQ = 3'd0;
    localparam logic [2:0] CMD_MK_CQ = 3'd1;
    localparam logic [2:0] CMD_RM_SQ = 3'd2;
    localparam logic [2:0] CMD_RM_CQ = 3'd3;
    localparam logic [2:0] CMD_DBELL = 3'd4;
    localparam logic [2:0] CMD_FETCH = 3'd5;
    localparam logic [2:0] CMD_POST  = 3'd6;

    // Result codes.
    localparam logic [2:0] RC_OK       = 3'd0;
    localparam logic [2:0] RC_BAD      = 3'd1;
    localparam logic [2:0] RC_EXISTS   = 3'd2;
    localparam logic [2:0] RC_NOTFOUND = 3'd3;
    localparam logic [2:0] RC_BUSY     = 3'd4;
    localparam logic [2:0] RC_EMPTY    = 3'd5;
    localparam logic [2:0] RC_INVALID  = 3'd6;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAX_IO = 2'd0;
    localparam logic [1:0] CFG_ASQ    = 2'd1;
    localparam logic [1:0] CFG_ACQ    = 2'd2;

    localparam logic [CAP_W-1:0] ADMIN_RST_SIZE = 13'd64;
    localparam logic [4:0]       MAX_IO_RST     = 5'd16;

    // Work left for the back end once the front end has classified a command.
    typedef enum logic [2:0] {
        K_RESULT = 3'd0,   // single result already decided
        K_MK_SQ  = 3'd1,
        K_MK_CQ  = 3'd2,
        K_DBELL  = 3'd3,
        K_FETCH  = 3'd4,
        K_POST   = 3'd5
    } t_kind;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] queue_id;
        logic [15:0] queue_size;
        logic [15:0] cq_id;
        logic [15:0] new_tail;
        logic [6:0]  max_fetch;
        logic [31:0] cpl_dw0;
        logic [31:0] cpl_dw1;
        logic [15:0] cpl_sq_head;
        logic [15:0] cpl_sq_id;
        logic [15:0] cpl_cid;
        logic [15:0] cpl_status;
    } t_item;

    typedef struct packed {
        logic [2:0]  result_code;
        logic [11:0] slot_index;
        logic        slot_valid;
        logic        last;
        logic [31:0] out_dw0;
        logic [31:0] out_dw1;
        logic [15:0] out_sq_head;
        logic [15:0] out_sq_id;
        logic [15:0] out_cid;
        logic [15:0] out_status_phase;
    } t_res;

    typedef struct packed {
        t_kind              kind;
        logic [2:0]         code;
        logic [QID_W-1:0]   qid;
        logic [CAP_W-1:0]   qsize;
        logic [15:0]        ntail;
        logic [MAXF_W-1:0]  maxf;
        logic [31:0]        dw0;
        logic [31:0]        dw1;
        logic [15:0]        sq_head;
        logic [15:0]        sq_id;
        logic [15:0]        cid;
        logic [15:0]        status;
    } t_op;

    typedef struct packed {
        logic             we;
        logic [1:0]       idx;
        logic [CAP_W-1:0] data;
    } t_cfg;

    function automatic logic [CAP_W-1:0] clamp_admin(input logic [CAP_W-1:0] v);
        logic [CAP_W-1:0] r;
        if (v < 13'd2) begin
            r = 13'd2;
        end else if (v > 13'd4096) begin
            r = 13'd4096;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/nvme_queue_pair_manager.sv @@
// Top level of the NVMe queue pair manager: front end, command queue and back end.
// Depends on qpm_pkg, qpm_front, qpm_fifo and qpm_back.
//
// Usage. Commands arrive on the input channel (i_in_valid, o_in_ready, i_in_data) as
// one transfer each: create or delete an I/O submission or completion queue, write a
// submission tail doorbell, fetch a batch of submitted slots, or post a completion.
// Results leave on the output channel (o_out_valid, i_out_ready, o_out_data); every
// command gives one result with last set, except a fetch that takes slots, which gives
// one result per slot taken and sets last on the final one. The configuration port
// (i_cfg_we, i_cfg_idx, i_cfg_data) sets the I/O queue limit and the admin queue sizes;
// the user must write it only while no command is outstanding, which the block does
// not enforce. Writing an admin size resets that admin queue's pointers.
// Timing. A command passes through the command queue, the back end's registered read
// of the per-queue pointer memories (S_IDLE) and its execute step (S_EXEC) to the
// output register. The back end takes no new command until it has finished the last;
// a fetch stays in S_FETCH after the execute step and gives one slot per cycle while
// i_out_ready is high.
// A two-entry queue lets the front end take and check further commands meanwhile.
// Reset. Synchronous and active low: the admin pair exists with 64 entries, no I/O
// queue exists, and both channels are empty. No clearing pass is needed.
// Stalls. While i_out_ready is low the output register holds its result, the back end
// waits, and once the command queue is full o_in_ready falls.
module nvme_queue_pair_manager #(
    parameter int NUM_IO_QUEUES   = 16,
    parameter int MAX_QUEUE_DEPTH = 1024,
    parameter int MAX_BATCH       = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [qpm_pkg::CAP_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  qpm_pkg::t_item              i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output qpm_pkg::t_res               o_out_data
);

    qpm_pkg::t_cfg cfg;
    qpm_pkg::t_op  push_op, head_op;
    logic          push, pop, q_empty, q_full;

    // The configuration write is shared: the limit sits in the front end and the
    // admin queue state in the back end.
    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    // The front end resolves every check that depends only on which queues exist,
    // so the exists flags are always up to date in command order.
    qpm_front #(
        .NUM_IO_QUEUES   (NUM_IO_QUEUES),
        .MAX_QUEUE_DEPTH (MAX_QUEUE_DEPTH),
        .MAX_BATCH       (MAX_BATCH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_full     (q_full),
        .o_push     (push),
        .o_op       (push_op)
    );

    qpm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_op    (head_op),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // The back end owns the ring pointers and capacities and produces all results.
    qpm_back #(
        .NUM_IO_QUEUES (NUM_IO_QUEUES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_empty     (q_empty),
        .i_op        (head_op),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    // Any failing code ends its command in a single result with no slot.
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.result_code != qpm_pkg::RC_OK))
        |-> (o_out_data.last && !o_out_data.slot_valid))
        else $error("failing result is not a single slotless result");

    // Only a batch fetch gives more than one result, and each of those carries a slot.
    a_mid_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.last)
        |-> (o_out_data.slot_valid && (o_out_data.result_code == qpm_pkg::RC_OK)
             && (o_out_data.out_status_phase == 16'd0)))
        else $error("non-final result is not a fetched slot");

    // A result without a slot carries a zero slot index and an empty entry.
    a_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.slot_valid)
        |-> ((o_out_data.slot_index == 12'd0) && (o_out_data.out_dw0 == 32'd0)
             && (o_out_data.out_cid == 16'd0)))
        else $error("slotless result carries slot or entry data");
`endif

endmodule

@@ rtl/core/qpm_front.sv @@
// Front end of the queue pair manager: accepts commands, runs the id, size and
// existence checks and owns the queue-exists flags. Depends on qpm_pkg.
module qpm_front #(
    parameter int NUM_IO_QUEUES   = 16,
    parameter int MAX_QUEUE_DEPTH = 1024,
    parameter int MAX_BATCH       = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  qpm_pkg::t_cfg i_cfg,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  qpm_pkg::t_item i_in_data,
    input  logic          i_full,
    output logic          o_push,
    output qpm_pkg::t_op  o_op
);

    localparam int NQ = NUM_IO_QUEUES + 1;
    localparam int AW = $clog2(NQ);
    localparam logic [qpm_pkg::QID_W-1:0] NIO = qpm_pkg::QID_W'(NUM_IO_QUEUES);
    localparam logic [15:0] MQD = 16'(MAX_QUEUE_DEPTH);
    localparam logic [qpm_pkg::MAXF_W-1:0] MB = qpm_pkg::MAXF_W'(MAX_BATCH);

    logic [4:0]    r_max_io;
    logic [NQ-1:0] r_sq_ex, n_sq_ex;
    logic [NQ-1:0] r_cq_ex, n_cq_ex;

    logic [qpm_pkg::QID_W-1:0] lim;
    logic [qpm_pkg::QID_W-1:0] max_io_x;
    logic [AW-1:0] q, cqx;
    logic qid_ok, qany, cqid_ok, size_ok;
    logic sq_hit, cq_hit, cq_lnk;
    logic set_sq, clr_sq, set_cq, clr_cq;
    logic [qpm_pkg::MAXF_W-1:0] mf;

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

    assign max_io_x = {{(qpm_pkg::QID_W-5){1'b0}}, r_max_io};
    assign lim      = (max_io_x > NIO) ? NIO : max_io_x;

    assign qid_ok  = (i_in_data.queue_id != 16'd0) &&
                     (i_in_data.queue_id <= {{(16-qpm_pkg::QID_W){1'b0}}, lim});
    assign qany    = (i_in_data.queue_id == 16'd0) || qid_ok;
    assign cqid_ok = (i_in_data.cq_id != 16'd0) &&
                     (i_in_data.cq_id <= {{(16-qpm_pkg::QID_W){1'b0}}, lim});
    assign size_ok = (i_in_data.queue_size != 16'd0) && (i_in_data.queue_size <= MQD);

    assign q   = i_in_data.queue_id[AW-1:0];
    assign cqx = i_in_data.cq_id[AW-1:0];

    // Flags are only looked up for ids already known to be in range.
    assign sq_hit = qany ? r_sq_ex[q] : 1'b0;
    assign cq_hit = qany ? r_cq_ex[q] : 1'b0;
    assign cq_lnk = cqid_ok ? r_cq_ex[cqx] : 1'b0;

    assign mf = (i_in_data.max_fetch > MB) ? MB : i_in_data.max_fetch;

    always_comb begin
        o_op.kind    = qpm_pkg::K_RESULT;
        o_op.code    = qpm_pkg::RC_OK;
        o_op.qid     = i_in_data.queue_id[qpm_pkg::QID_W-1:0];
        o_op.qsize   = i_in_data.queue_size[qpm_pkg::CAP_W-1:0];
        o_op.ntail   = i_in_data.new_tail;
        o_op.maxf    = mf;
        o_op.dw0     = i_in_data.cpl_dw0;
        o_op.dw1     = i_in_data.cpl_dw1;
        o_op.sq_head = i_in_data.cpl_sq_head;
        o_op.sq_id   = i_in_data.cpl_sq_id;
        o_op.cid     = i_in_data.cpl_cid;
        o_op.status  = i_in_data.cpl_status;
        set_sq = 1'b0;
        clr_sq = 1'b0;
        set_cq = 1'b0;
        clr_cq = 1'b0;
        case (i_in_data.cmd)
            qpm_pkg::CMD_MK_SQ: begin
                if (!qid_ok || !size_ok || !cqid_ok || !cq_lnk) begin
                    o_op.code = qpm_pkg::RC_BAD;
                end else if (sq_hit) begin
                    o_op.code = qpm_pkg::RC_EXISTS;
                end else begin
                    o_op.kind = qpm_pkg::K_MK_SQ;
                    set_sq    = 1'b1;
                end
            end
            qpm_pkg::CMD_MK_CQ: begin
                if (!qid_ok || !size_ok) begin
                    o_op.code = qpm_pkg::RC_BAD;
                end else if (cq_hit) begin
                    o_op.code = qpm_pkg::RC_EXISTS;
                end else begin
                    o_op.kind = qpm_pkg::K_MK_CQ;
                    set_cq    = 1'b1;
                end
            end
            qpm_pkg::CMD_RM_SQ: begin
                if (!qid_ok) begin
                    o_op.code = qpm_pkg::RC_BAD;
                end else if (!sq_hit) begin
                    o_op.code = qpm_pkg::RC_NOTFOUND;
                end else begin
                    clr_sq = 1'b1;
                end
            end
            qpm_pkg::CMD_RM_CQ: begin
                if (!qid_ok) begin
                    o_op.code = qpm_pkg::RC_BAD;
                end else if (!cq_hit) begin
                    o_op.code = qpm_pkg::RC_NOTFOUND;
                end else if (sq_hit) begin
                    o_op.code = qpm_pkg::RC_BUSY;
                end else begin
                    clr_cq = 1'b1;
                end
            end
            qpm_pkg::CMD_DBELL: begin
                if (!qany) begin
                    o_op.code = qpm_pkg::RC_BAD;
                end else if (!sq_hit) begin
                    o_op.code = qpm_pkg::RC_INVALID;
                end else begin
                    o_op.kind = qpm_pkg::K_DBELL;
                end
            end
            qpm_pkg::CMD_FETCH: begin
                if (!qany) begin
                    o_op.code = qpm_pkg::RC_BAD;
                end else if (!sq_hit) begin
                    o_op.code = qpm_pkg::RC_INVALID;
                end else begin
                    o_op.kind = qpm_pkg::K_FETCH;
                end
            end
            qpm_pkg::CMD_POST: begin
                if (!qany) begin
                    o_op.code = qpm_pkg::RC_BAD;
                end else if (!cq_hit) begin
                    o_op.code = qpm_pkg::RC_INVALID;
                end else begin
                    o_op.kind = qpm_pkg::K_POST;
                end
            end
            default: begin
                o_op.code = qpm_pkg::RC_BAD;
            end
        endcase
    end

    always_comb begin
        n_sq_ex = r_sq_ex;
        n_cq_ex = r_cq_ex;
        if (o_push) begin
            if (set_sq) begin
                n_sq_ex[q] = 1'b1;
            end
            if (clr_sq) begin
                n_sq_ex[q] = 1'b0;
            end
            if (set_cq) begin
                n_cq_ex[q] = 1'b1;
            end
            if (clr_cq) begin
                n_cq_ex[q] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_io <= qpm_pkg::MAX_IO_RST;
            r_sq_ex  <= NQ'(1);
            r_cq_ex  <= NQ'(1);
        end else begin
            r_sq_ex <= n_sq_ex;
            r_cq_ex <= n_cq_ex;
            if (i_cfg.we && (i_cfg.idx == qpm_pkg::CFG_MAX_IO)) begin
                r_max_io <= i_cfg.data[4:0];
            end
        end
    end

endmodule

@@ rtl/core/qpm_fifo.sv @@
// Two-entry queue of classified commands between the front and back ends.
// Depends on qpm_pkg for the command record type.
module qpm_fifo (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  qpm_pkg::t_op i_op,
    input  logic         i_pop,
    output qpm_pkg::t_op o_op,
    output logic         o_empty,
    output logic         o_full
);

    qpm_pkg::t_op r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_op    = r_mem[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ rtl/core/qpm_back.sv @@
// Back end of the queue pair manager: ring pointer memories, admin queue registers,
// doorbell, batch fetch and completion post, and the output register. Depends on qpm_pkg.
module qpm_back #(
    parameter int NUM_IO_QUEUES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  qpm_pkg::t_cfg i_cfg,
    input  logic          i_empty,
    input  qpm_pkg::t_op  i_op,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output qpm_pkg::t_res o_out_data
);

    localparam int NQ    = NUM_IO_QUEUES + 1;
    localparam int AW    = $clog2(NQ);
    localparam int PW    = qpm_pkg::PTR_W;
    localparam int CW    = qpm_pkg::CAP_W;
    localparam int SQ_DW = CW + 2 * PW;   // {capacity, tail, head}
    localparam int CQ_DW = 1 + CW + PW;   // {phase, capacity, tail}

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EXEC  = 3'b010,
        S_FETCH = 3'b100
    } t_bstate;

    t_bstate r_state, n_state;
    qpm_pkg::t_op r_op;

    logic [SQ_DW-1:0] r_sq_mem [NQ];
    logic [CQ_DW-1:0] r_cq_mem [NQ];
    logic [SQ_DW-1:0] r_sq_rd;
    logic [CQ_DW-1:0] r_cq_rd;

    // Admin pair lives in registers so that reset and configuration can set it.
    logic [PW-1:0] r_asq_head, r_asq_tail, r_acq_tail;
    logic [CW-1:0] r_asq_cap, r_acq_cap;
    logic          r_acq_ph;

    // Batch fetch working registers.
    logic [PW-1:0] r_head, n_head, r_tail, n_tail;
    logic [CW-1:0] r_cap, n_cap;
    logic [qpm_pkg::MAXF_W-1:0] r_cnt, n_cnt;

    logic          r_out_valid;
    qpm_pkg::t_res r_out;

    logic          is_admin, ld, res_ld;
    qpm_pkg::t_res res;
    logic [PW-1:0] c_sq_head, c_sq_tail, c_cq_tail;
    logic [CW-1:0] c_sq_cap, c_cq_cap;
    logic          c_cq_ph;
    logic          sq_wr, cq_wr;
    logic [SQ_DW-1:0] sq_wd;
    logic [CQ_DW-1:0] cq_wd;
    logic [CW-1:0] inc, f_inc;
    logic [PW-1:0] nxt, f_nxt;
    logic          wrap, f_last;

    assign o_pop       = (r_state == S_IDLE) && !i_empty;
    assign ld          = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign is_admin    = (r_op.qid == '0);

    assign c_sq_head = is_admin ? r_asq_head : r_sq_rd[PW-1:0];
    assign c_sq_tail = is_admin ? r_asq_tail : r_sq_rd[2*PW-1:PW];
    assign c_sq_cap  = is_admin ? r_asq_cap  : r_sq_rd[SQ_DW-1:2*PW];
    assign c_cq_tail = is_admin ? r_acq_tail : r_cq_rd[PW-1:0];
    assign c_cq_cap  = is_admin ? r_acq_cap  : r_cq_rd[CQ_DW-2:PW];
    assign c_cq_ph   = is_admin ? r_acq_ph   : r_cq_rd[CQ_DW-1];

    // Completion tail step, wrapping at the capacity.
    assign inc  = {1'b0, c_cq_tail} + 13'd1;
    assign wrap = (inc == c_cq_cap);
    assign nxt  = wrap ? '0 : inc[PW-1:0];

    // Submission head step during a batch fetch.
    assign f_inc  = {1'b0, r_head} + 13'd1;
    assign f_nxt  = (f_inc == r_cap) ? '0 : f_inc[PW-1:0];
    assign f_last = (f_nxt == r_tail) || (r_cnt == qpm_pkg::MAXF_W'(1));

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_tail  = r_tail;
        n_cap   = r_cap;
        n_cnt   = r_cnt;
        res_ld  = 1'b0;
        res     = '0;
        res.last = 1'b1;
        sq_wr   = 1'b0;
        cq_wr   = 1'b0;
        sq_wd   = {c_sq_cap, c_sq_tail, c_sq_head};
        cq_wd   = {c_cq_ph, c_cq_cap, c_cq_tail};
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (ld) begin
                    n_state = S_IDLE;
                    res_ld  = 1'b1;
                    case (r_op.kind)
                        qpm_pkg::K_RESULT: begin
                            res.result_code = r_op.code;
                        end
                        qpm_pkg::K_MK_SQ: begin
                            sq_wr = 1'b1;
                            sq_wd = {r_op.qsize, {PW{1'b0}}, {PW{1'b0}}};
                        end
                        qpm_pkg::K_MK_CQ: begin
                            cq_wr = 1'b1;
                            cq_wd = {1'b1, r_op.qsize, {PW{1'b0}}};
                        end
                        qpm_pkg::K_DBELL: begin
                            if (r_op.ntail >= {3'b000, c_sq_cap}) begin
                                res.result_code = qpm_pkg::RC_BAD;
                            end else begin
                                sq_wr = 1'b1;
                                sq_wd = {c_sq_cap, r_op.ntail[PW-1:0], c_sq_head};
                            end
                        end
                        qpm_pkg::K_FETCH: begin
                            if (c_sq_cap == '0) begin
                                res.result_code = qpm_pkg::RC_INVALID;
                            end else if (r_op.maxf == '0) begin
                                res.result_code = qpm_pkg::RC_OK;
                            end else if (c_sq_head == c_sq_tail) begin
                                res.result_code = qpm_pkg::RC_EMPTY;
                            end else begin
                                res_ld  = 1'b0;
                                n_state = S_FETCH;
                                n_head  = c_sq_head;
                                n_tail  = c_sq_tail;
                                n_cap   = c_sq_cap;
                                n_cnt   = r_op.maxf;
                            end
                        end
                        qpm_pkg::K_POST: begin
                            if (c_cq_cap == '0) begin
                                res.result_code = qpm_pkg::RC_INVALID;
                            end else begin
                                res.slot_index       = c_cq_tail;
                                res.slot_valid       = 1'b1;
                                res.out_dw0          = r_op.dw0;
                                res.out_dw1          = r_op.dw1;
                                res.out_sq_head      = r_op.sq_head;
                                res.out_sq_id        = r_op.sq_id;
                                res.out_cid          = r_op.cid;
                                res.out_status_phase = {r_op.status[15:1], c_cq_ph};
                                cq_wr = 1'b1;
                                cq_wd = {c_cq_ph ^ wrap, c_cq_cap, nxt};
                            end
                        end
                        default: begin
                            res.result_code = qpm_pkg::RC_BAD;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                if (ld) begin
                    res_ld         = 1'b1;
                    res.slot_index = r_head;
                    res.slot_valid = 1'b1;
                    res.last       = f_last;
                    n_head         = f_nxt;
                    n_cnt          = r_cnt - qpm_pkg::MAXF_W'(1);
                    if (f_last) begin
                        n_state = S_IDLE;
                        sq_wr   = 1'b1;
                        sq_wd   = {r_cap, r_tail, f_nxt};
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Pointer memories: one write and one registered read per cycle each.
    always_ff @(posedge i_clk) begin
        if (sq_wr && !is_admin) begin
            r_sq_mem[r_op.qid[AW-1:0]] <= sq_wd;
        end
        if (cq_wr && !is_admin) begin
            r_cq_mem[r_op.qid[AW-1:0]] <= cq_wd;
        end
        if (o_pop) begin
            r_sq_rd <= r_sq_mem[i_op.qid[AW-1:0]];
            r_cq_rd <= r_cq_mem[i_op.qid[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op <= i_op;
        end
        r_head <= n_head;
        r_tail <= n_tail;
        r_cap  <= n_cap;
        r_cnt  <= n_cnt;
        if (res_ld) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_asq_head  <= '0;
            r_asq_tail  <= '0;
            r_asq_cap   <= qpm_pkg::ADMIN_RST_SIZE;
            r_acq_tail  <= '0;
            r_acq_cap   <= qpm_pkg::ADMIN_RST_SIZE;
            r_acq_ph    <= 1'b1;
        end else begin
            r_state <= n_state;
            if (res_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (sq_wr && is_admin) begin
                r_asq_head <= sq_wd[PW-1:0];
                r_asq_tail <= sq_wd[2*PW-1:PW];
            end
            if (cq_wr && is_admin) begin
                r_acq_tail <= cq_wd[PW-1:0];
                r_acq_ph   <= cq_wd[CQ_DW-1];
            end
            if (i_cfg.we && (i_cfg.idx == qpm_pkg::CFG_ASQ)) begin
                r_asq_cap  <= qpm_pkg::clamp_admin(i_cfg.data);
                r_asq_head <= '0;
                r_asq_tail <= '0;
            end
            if (i_cfg.we && (i_cfg.idx == qpm_pkg::CFG_ACQ)) begin
                r_acq_cap  <= qpm_pkg::clamp_admin(i_cfg.data);
                r_acq_tail <= '0;
                r_acq_ph   <= 1'b1;
            end
        end
    end

endmodule

@@ dv/qpm_checker.sv @@
// Result checker for the NVMe queue pair manager: watches both channels and the
// configuration port, predicts every result and compares it with what the block sends.
// Depends on qpm_pkg for the transfer types and the command, result and register codes.
`timescale 1ns / 100ps

module qpm_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [qpm_pkg::CAP_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  qpm_pkg::t_item            i_in_data,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  qpm_pkg::t_res             i_out_data,
    output int                        o_fail_count,
    output int                        o_pending
);
    import qpm_pkg::*;

    localparam int          NUM_IO      = 16;
    localparam int          DEPTH_LIMIT = 1024;
    localparam int          BATCH_LIMIT = 64;
    localparam logic [15:0] STATUS_KEEP = 16'hFFFE;
    localparam int          SLOT_MASK   = 'hFFF;

    // Shadow of the per-queue ring state, index 0 being the admin pair.
    logic [11:0] sq_hd  [0:NUM_IO];
    logic [11:0] sq_tl  [0:NUM_IO];
    logic [12:0] sq_cap [0:NUM_IO];
    logic        sq_on  [0:NUM_IO];
    logic [11:0] cq_tl  [0:NUM_IO];
    logic [12:0] cq_cap [0:NUM_IO];
    logic        cq_ph  [0:NUM_IO];
    logic        cq_on  [0:NUM_IO];
    logic [4:0]  io_max;

    t_res expected_results[$];
    int   mismatch_count = 0;

    function automatic logic [12:0] admin_size(input logic [12:0] v);
        logic [12:0] r;
        r = v;
        if (v < 13'd2) begin
            r = 13'd2;
        end else if (v > 13'd4096) begin
            r = 13'd4096;
        end
        return r;
    endfunction

    function automatic bit io_id_ok(input logic [15:0] id);
        int lim;
        lim = (io_max > NUM_IO) ? NUM_IO : int'(io_max);
        return (id >= 16'd1) && (int'(id) <= lim);
    endfunction

    function automatic t_res plain_result(input logic [2:0] code, input logic [11:0] slot,
                                          input logic vld, input logic lst);
        t_res r;
        r = '0;
        r.result_code = code;
        r.slot_index  = slot;
        r.slot_valid  = vld;
        r.last        = lst;
        return r;
    endfunction

    task automatic expect_single(input logic [2:0] code);
        expected_results.push_back(plain_result(code, 12'd0, 1'b0, 1'b1));
    endtask

    task automatic reset_model();
        for (int i = 0; i <= NUM_IO; i++) begin
            sq_hd[i]  = '0;
            sq_tl[i]  = '0;
            sq_cap[i] = '0;
            sq_on[i]  = 1'b0;
            cq_tl[i]  = '0;
            cq_cap[i] = '0;
            cq_ph[i]  = 1'b1;
            cq_on[i]  = 1'b0;
        end
        sq_cap[0] = ADMIN_RST_SIZE;
        cq_cap[0] = ADMIN_RST_SIZE;
        sq_on[0]  = 1'b1;
        cq_on[0]  = 1'b1;
        io_max    = MAX_IO_RST;
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [12:0] data);
        case (idx)
            CFG_MAX_IO: io_max = data[4:0];
            CFG_ASQ: begin
                sq_cap[0] = admin_size(data);
                sq_hd[0]  = '0;
                sq_tl[0]  = '0;
                sq_on[0]  = 1'b1;
            end
            CFG_ACQ: begin
                cq_cap[0] = admin_size(data);
                cq_tl[0]  = '0;
                cq_ph[0]  = 1'b1;
                cq_on[0]  = 1'b1;
            end
            default: ;
        endcase
    endtask

    // Works out the results of one command and applies its effect on the rings.
    task automatic predict_command(input t_item it);
        int   q;
        int   n;
        int   head;
        int   tail;
        int   cap;
        int   maxf;
        bit   any_ok;
        t_res r;
        q      = int'(it.queue_id);
        any_ok = (it.queue_id == 16'd0) || io_id_ok(it.queue_id);
        case (it.cmd)
            CMD_MK_SQ, CMD_MK_CQ: begin
                if (!io_id_ok(it.queue_id) || it.queue_size == 16'd0
                        || int'(it.queue_size) > DEPTH_LIMIT) begin
                    expect_single(RC_BAD);
                end else if (it.cmd == CMD_MK_SQ) begin
                    if (!io_id_ok(it.cq_id) || !cq_on[int'(it.cq_id)]) begin
                        expect_single(RC_BAD);
                    end else if (sq_on[q]) begin
                        expect_single(RC_EXISTS);
                    end else begin
                        sq_cap[q] = it.queue_size[12:0];
                        sq_hd[q]  = '0;
                        sq_tl[q]  = '0;
                        sq_on[q]  = 1'b1;
                        expect_single(RC_OK);
                    end
                end else if (cq_on[q]) begin
                    expect_single(RC_EXISTS);
                end else begin
                    cq_cap[q] = it.queue_size[12:0];
                    cq_tl[q]  = '0;
                    cq_ph[q]  = 1'b1;
                    cq_on[q]  = 1'b1;
                    expect_single(RC_OK);
                end
            end
            CMD_RM_SQ: begin
                if (!io_id_ok(it.queue_id)) begin
                    expect_single(RC_BAD);
                end else if (!sq_on[q]) begin
                    expect_single(RC_NOTFOUND);
                end else begin
                    sq_on[q]  = 1'b0;
                    sq_cap[q] = '0;
                    sq_hd[q]  = '0;
                    sq_tl[q]  = '0;
                    expect_single(RC_OK);
                end
            end
            CMD_RM_CQ: begin
                if (!io_id_ok(it.queue_id)) begin
                    expect_single(RC_BAD);
                end else if (!cq_on[q]) begin
                    expect_single(RC_NOTFOUND);
                end else if (sq_on[q]) begin
                    expect_single(RC_BUSY);
                end else begin
                    cq_on[q]  = 1'b0;
                    cq_cap[q] = '0;
                    cq_tl[q]  = '0;
                    cq_ph[q]  = 1'b1;
                    expect_single(RC_OK);
                end
            end
            CMD_DBELL: begin
                if (!any_ok) begin
                    expect_single(RC_BAD);
                end else if (!sq_on[q]) begin
                    expect_single(RC_INVALID);
                end else if (it.new_tail >= {3'd0, sq_cap[q]}) begin
                    expect_single(RC_BAD);
                end else begin
                    sq_tl[q] = it.new_tail[11:0];
                    expect_single(RC_OK);
                end
            end
            CMD_FETCH: begin
                if (!any_ok) begin
                    expect_single(RC_BAD);
                end else if (!sq_on[q] || sq_cap[q] == '0) begin
                    expect_single(RC_INVALID);
                end else begin
                    maxf = (int'(it.max_fetch) > BATCH_LIMIT) ? BATCH_LIMIT
                                                              : int'(it.max_fetch);
                    head = int'(sq_hd[q]);
                    tail = int'(sq_tl[q]);
                    cap  = int'(sq_cap[q]);
                    if (maxf == 0) begin
                        expect_single(RC_OK);
                    end else if (head == tail) begin
                        expect_single(RC_EMPTY);
                    end else begin
                        n = 0;
                        while (head != tail && n < maxf) begin
                            r = plain_result(RC_OK, 12'(head), 1'b1, 1'b0);
                            head = (head + 1) % cap;
                            n++;
                            r.last = (head == tail) || (n == maxf);
                            expected_results.push_back(r);
                        end
                        sq_hd[q] = 12'(head & SLOT_MASK);
                    end
                end
            end
            CMD_POST: begin
                if (!any_ok) begin
                    expect_single(RC_BAD);
                end else if (!cq_on[q] || cq_cap[q] == '0) begin
                    expect_single(RC_INVALID);
                end else begin
                    r = plain_result(RC_OK, cq_tl[q], 1'b1, 1'b1);
                    r.out_dw0          = it.cpl_dw0;
                    r.out_dw1          = it.cpl_dw1;
                    r.out_sq_head      = it.cpl_sq_head;
                    r.out_sq_id        = it.cpl_sq_id;
                    r.out_cid          = it.cpl_cid;
                    r.out_status_phase = (it.cpl_status & STATUS_KEEP) | {15'd0, cq_ph[q]};
                    expected_results.push_back(r);
                    // The phase flips each time the tail wraps back to slot zero.
                    tail = (int'(cq_tl[q]) + 1) % int'(cq_cap[q]);
                    if (tail == 0) begin
                        cq_ph[q] = ~cq_ph[q];
                    end
                    cq_tl[q] = 12'(tail & SLOT_MASK);
                end
            end
            default: expect_single(RC_BAD);
        endcase
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result(input t_res got);
        t_res want;
        if (expected_results.size() == 0) begin
            $display("%0t: result %h arrived with none expected", $time, got);
            mismatch_count++;
        end else begin
            want = expected_results.pop_front();
            compare_field("result_code", 32'(want.result_code), 32'(got.result_code));
            compare_field("slot_index", 32'(want.slot_index), 32'(got.slot_index));
            compare_field("slot_valid", 32'(want.slot_valid), 32'(got.slot_valid));
            compare_field("last", 32'(want.last), 32'(got.last));
            compare_field("out_dw0", want.out_dw0, got.out_dw0);
            compare_field("out_dw1", want.out_dw1, got.out_dw1);
            compare_field("out_sq_head", 32'(want.out_sq_head), 32'(got.out_sq_head));
            compare_field("out_sq_id", 32'(want.out_sq_id), 32'(got.out_sq_id));
            compare_field("out_cid", 32'(want.out_cid), 32'(got.out_cid));
            compare_field("out_status_phase", 32'(want.out_status_phase),
                          32'(got.out_status_phase));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                write_register(i_cfg_idx, i_cfg_data);
            end
            if (i_in_valid && i_in_ready) begin
                predict_command(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                check_result(i_out_data);
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= expected_results.size();
    end

endmodule

@@ dv/tb_top.sv @@
// Testbench top for the NVMe queue pair manager: clock, reset, command stimulus,
// result back-pressure, configuration phases and the final verdict.
// Depends on qpm_pkg, the block under test and the qpm_checker module.
`timescale 1ns / 100ps

module tb_top;
    import qpm_pkg::*;

    // Command code seven has no meaning and must be rejected as a bad parameter.
    localparam logic [2:0] CMD_SPARE = 3'd7;

    // Consecutive cycles without any transfer before the run is declared stuck. The
    // slowest legal stretch is a drain plus settle and the three register writes, well
    // within this limit, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT   = 2000;
    // Quiet cycles after the last expected result; the block is already idle by then,
    // so this only spaces the phases apart.
    localparam int SETTLE_CYCLES    = 80;
    localparam int PHASES           = 6;
    localparam int RANDOM_PER_PHASE = 50;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [1:0]          cfg_idx   = CFG_MAX_IO;
    logic [CAP_W-1:0]    cfg_data  = '0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    t_item               in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b1;
    t_res                out_data;

    int fail_count;
    int pending;

    // Per-phase switches that turn idling off on one side or the other, so that some
    // stretches run with back-to-back transfers.
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;

    int rx_hold = 0;
    int rx_draw;
    int quiet_cycles = 0;

    // Register settings per phase, the extremes among them. The I/O limit is written
    // once with its unused upper data bits set, and admin sizes below two and above
    // 4096 are written so the clamping is exercised.
    logic [CAP_W-1:0] max_io_plan [PHASES] = '{13'd16, 13'd1, 13'd31, 13'h1FE0, 13'd5, 13'd16};
    logic [CAP_W-1:0] asq_plan    [PHASES] = '{13'd64, 13'd2, 13'd8191, 13'd0, 13'd7, 13'd4096};
    logic [CAP_W-1:0] acq_plan    [PHASES] = '{13'd64, 13'd2, 13'd4096, 13'd3, 13'd5, 13'd8191};

    always #2 clk = ~clk;

    nvme_queue_pair_manager dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    qpm_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result side. After each transfer the receiver draws a random stall, and while
    // nothing is offered it sometimes drops ready as well, so that stalls land on every
    // part of a fetch burst and not only after a transfer.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b1;
            rx_hold   <= 0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            if (rx_hold == 1) begin
                out_ready <= 1'b1;
            end
        end else if (out_valid && out_ready) begin
            rx_draw = rx_steady ? 0 : $urandom_range(0, 4);
            rx_hold <= rx_draw;
            if (rx_draw != 0) begin
                out_ready <= 1'b0;
            end
        end else if (!rx_steady && $urandom_range(0, 7) == 0) begin
            rx_hold   <= $urandom_range(1, 4);
            out_ready <= 1'b0;
        end
    end

    // Watchdog: any transfer on either channel counts as progress.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // A command with every payload field random; callers then shape the fields that
    // matter for the case at hand.
    function automatic t_item make_item(input logic [2:0] cmd, input logic [15:0] qid);
        t_item it;
        it.cmd         = cmd;
        it.queue_id    = qid;
        it.queue_size  = 16'($urandom);
        it.cq_id       = 16'($urandom);
        it.new_tail    = 16'($urandom);
        it.max_fetch   = 7'($urandom);
        it.cpl_dw0     = $urandom;
        it.cpl_dw1     = $urandom;
        it.cpl_sq_head = 16'($urandom);
        it.cpl_sq_id   = 16'($urandom);
        it.cpl_cid     = 16'($urandom);
        it.cpl_status  = 16'($urandom);
        return it;
    endfunction

    // Most random commands are well formed: small queue ids, small rings, each SQ
    // usually linked to the CQ of the same id, and tails inside the ring, so that
    // doorbells, fetches and posts get past the existence checks. The rest is noise.
    function automatic t_item random_item();
        t_item it;
        int    pick;
        it = make_item(3'($urandom_range(0, 7)), 16'($urandom));
        if ($urandom_range(0, 99) < 20) begin
            return it;
        end
        it.queue_id = 16'($urandom_range(0, 6));
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            it.cmd = CMD_MK_CQ;
        end else if (pick < 24) begin
            it.cmd = CMD_MK_SQ;
        end else if (pick < 30) begin
            it.cmd = CMD_RM_SQ;
        end else if (pick < 34) begin
            it.cmd = CMD_RM_CQ;
        end else if (pick < 56) begin
            it.cmd = CMD_DBELL;
        end else if (pick < 78) begin
            it.cmd = CMD_FETCH;
        end else begin
            it.cmd = CMD_POST;
        end
        it.queue_size = ($urandom_range(0, 19) == 0) ? 16'd1024 : 16'($urandom_range(1, 12));
        it.cq_id      = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 6)) : it.queue_id;
        it.new_tail   = 16'($urandom_range(0, 12));
        it.max_fetch  = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(64, 127))
                                                    : 7'($urandom_range(0, 8));
        return it;
    endfunction

    // One command transfer. The sender may idle first; valid then stays high with the
    // payload fixed until the block takes it. Valid is not lowered after a transfer,
    // so a following command with no gap keeps it high without a glitch.
    task automatic send_item(input t_item it);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
    endtask

    // Hold off the sender until every expected result has arrived, then let the
    // block settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_registers(input logic [CAP_W-1:0] max_io, input logic [CAP_W-1:0] asq,
                                 input logic [CAP_W-1:0] acq);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_MAX_IO;
        cfg_data <= max_io;
        @(posedge clk);
        cfg_idx  <= CFG_ASQ;
        cfg_data <= asq;
        @(posedge clk);
        cfg_idx  <= CFG_ACQ;
        cfg_data <= acq;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        t_item d;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, run with the reset register values.
        // An SQ whose linked CQ does not exist yet is rejected.
        d = make_item(CMD_MK_SQ, 16'd1);
        d.queue_size = 16'd8;
        d.cq_id      = 16'd1;
        send_item(d);
        // Admin and out-of-range ids cannot be created.
        d = make_item(CMD_MK_CQ, 16'd0);
        d.queue_size = 16'd4;
        send_item(d);
        d = make_item(CMD_MK_CQ, 16'd17);
        d.queue_size = 16'd4;
        send_item(d);
        // Sizes of zero and just above the depth limit are rejected.
        d = make_item(CMD_MK_CQ, 16'd1);
        d.queue_size = 16'd0;
        send_item(d);
        d = make_item(CMD_MK_CQ, 16'd1);
        d.queue_size = 16'd1025;
        send_item(d);
        d = make_item(CMD_MK_CQ, 16'd1);
        d.queue_size = 16'd4;
        send_item(d);
        // Second create of the same CQ reports that it exists.
        send_item(d);
        d = make_item(CMD_MK_SQ, 16'd1);
        d.queue_size = 16'd1024;
        d.cq_id      = 16'd1;
        send_item(d);
        send_item(d);
        d = make_item(CMD_MK_SQ, 16'd2);
        d.queue_size = 16'd4;
        d.cq_id      = 16'hFFFF;
        send_item(d);
        // A CQ still used by its SQ is busy; admin and absent queues cannot be deleted.
        send_item(make_item(CMD_RM_CQ, 16'd1));
        send_item(make_item(CMD_RM_SQ, 16'd0));
        send_item(make_item(CMD_RM_SQ, 16'd3));
        send_item(make_item(CMD_RM_CQ, 16'd5));
        // Doorbells: missing queue, out-of-range id, tail at capacity, tail just inside.
        send_item(make_item(CMD_DBELL, 16'd5));
        send_item(make_item(CMD_DBELL, 16'hFFFF));
        d = make_item(CMD_DBELL, 16'd1);
        d.new_tail = 16'd1024;
        send_item(d);
        d.new_tail = 16'd1023;
        send_item(d);
        // Fetch with a zero limit, then two full batches, one asked above the limit.
        d = make_item(CMD_FETCH, 16'd1);
        d.max_fetch = 7'd0;
        send_item(d);
        d.max_fetch = 7'd127;
        send_item(d);
        d.max_fetch = 7'd64;
        send_item(d);
        // The admin SQ starts empty.
        send_item(make_item(CMD_FETCH, 16'd0));
        // Five posts to a four-entry CQ wrap the tail and flip the phase; the first
        // carries an all-ones entry, whose status bit zero must be replaced.
        d = make_item(CMD_POST, 16'd1);
        d.cpl_dw0     = 32'hFFFF_FFFF;
        d.cpl_dw1     = 32'hFFFF_FFFF;
        d.cpl_sq_head = 16'hFFFF;
        d.cpl_sq_id   = 16'hFFFF;
        d.cpl_cid     = 16'hFFFF;
        d.cpl_status  = 16'hFFFF;
        send_item(d);
        repeat (4) send_item(make_item(CMD_POST, 16'd1));
        send_item(make_item(CMD_POST, 16'd3));
        send_item(make_item(CMD_SPARE, 16'd1));
        send_item(make_item(CMD_RM_SQ, 16'd1));
        send_item(make_item(CMD_RM_CQ, 16'd1));

        // Random phases, each under its own register setting and idling mix. Every
        // phase begins with a drain, so the sender pauses until all results are in.
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            set_registers(max_io_plan[p], asq_plan[p], acq_plan[p]);
            tx_steady = (p == 1) || (p == 4);
            rx_steady = (p == 2) || (p == 4);
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                send_item(random_item());
            end
        end

        drain_results();
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/qpm_pkg.sv
rtl/core/qpm_front.sv
rtl/core/qpm_fifo.sv
rtl/core/qpm_back.sv
rtl/core/nvme_queue_pair_manager.sv
dv/qpm_checker.sv
dv/tb_top.sv
